FILE: rtl/plid_pkg.sv
`timescale 1ns / 1ps

package plid_pkg;

    // Default number of list slots.
    localparam int unsigned PLID_CAPACITY = 16;

    // Width of one list element.
    localparam int unsigned ELEM_W = 32;

    // Request codes carried on req_type.
    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_READ   = 2'd2
    } plid_req_t;

    // Status codes returned with every response word.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } plid_status_t;

    // Shift command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } plid_cmd_t;

endpackage

FILE: rtl/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// Latency: a response word is registered in the cycle after its request word is accepted.
// Throughput: one request per cycle while each response is taken; every cell shifts in parallel.
// A new request is taken while the previous response waits, as long as it is taken then.
// Reset: rst_n clears the element count and the response valid; the list starts empty
// and stored elements hold no reset value.

module positional_list_insert_delete
    import plid_pkg::*;
#(
    parameter int unsigned CAPACITY = PLID_CAPACITY,
    parameter int unsigned CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  logic [1:0]               req_type,
    input  logic [CNT_W-1:0]         position,
    input  logic signed [ELEM_W-1:0] new_value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [ELEM_W-1:0] out_value,
    output logic [1:0]               status,
    output logic [CNT_W-1:0]         element_count
);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                     accept;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic signed [ELEM_W-1:0] out_value_reg;
    logic signed [ELEM_W-1:0] out_value_next;
    plid_status_t             status_reg;
    plid_status_t             status_next;
    logic [CNT_W-1:0]         element_count_reg;
    plid_cmd_t                cmd;
    logic                     take_word;

    logic signed [ELEM_W-1:0] cell_value [CAPACITY];
    logic signed [ELEM_W-1:0] cell_rd    [CAPACITY];
    logic signed [ELEM_W-1:0] rd_acc     [CAPACITY+1];

    // The response register frees up whenever its word is taken.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    // Chain of cells, each linked to both neighbors.
    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic signed [ELEM_W-1:0] lower;
            logic signed [ELEM_W-1:0] upper;

            if (g == 0)
            begin : g_first
                assign lower = '0;
            end
            else
            begin : g_mid_lo
                assign lower = cell_value[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign upper = '0;
            end
            else
            begin : g_mid_hi
                assign upper = cell_value[g+1];
            end

            plid_cell #(
                .IDX   (g),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .position    (position),
                .new_value   (new_value),
                .lower_value (lower),
                .upper_value (upper),
                .value       (cell_value[g]),
                .rd_word     (cell_rd[g])
            );

            // At most one cell drives its tap, so the taps are merged with OR.
            assign rd_acc[g+1] = rd_acc[g] | cell_rd[g];
        end
    endgenerate

    assign rd_acc[0] = '0;

    // Request decode: range and full checks, shift command and the new count.
    always_comb
    begin
        cmd            = '0;
        take_word      = 1'b0;
        status_next    = ST_RANGE;
        count_next     = count_reg;
        case (plid_req_t'(req_type))
            REQ_INSERT:
            begin
                if (position > count_reg)
                begin
                    status_next = ST_RANGE;
                end
                else if (count_reg == CAP_CNT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    cmd.ins     = accept;
                    count_next  = count_reg + 1'b1;
                end
            end
            REQ_DELETE, REQ_READ:
            begin
                if ((position == '0) || (position > count_reg))
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    status_next = ST_OK;
                    take_word   = 1'b1;
                    if (plid_req_t'(req_type) == REQ_DELETE)
                    begin
                        cmd.del    = accept;
                        count_next = count_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
        out_value_next = take_word ? rd_acc[CAPACITY] : '0;
    end

    // Response valid follows the handshake on both sides.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Response payload, loaded with each accepted request.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_value_reg     <= out_value_next;
            status_reg        <= status_next;
            element_count_reg <= count_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign out_value     = out_value_reg;
    assign status        = status_reg;
    assign element_count = element_count_reg;

endmodule

FILE: rtl/plid_cell.sv
`timescale 1ns / 1ps

module plid_cell
    import plid_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
)
(
    input  logic                     clk,
    input  plid_cmd_t                cmd,
    input  logic [CNT_W-1:0]         position,
    input  logic signed [ELEM_W-1:0] new_value,
    input  logic signed [ELEM_W-1:0] lower_value,
    input  logic signed [ELEM_W-1:0] upper_value,
    output logic signed [ELEM_W-1:0] value,
    output logic signed [ELEM_W-1:0] rd_word
);

    // Slot index (0-based) and element number (1-based) of this cell.
    localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] MY_NUM  = CNT_W'(IDX + 1);

    logic signed [ELEM_W-1:0] value_reg;
    logic signed [ELEM_W-1:0] value_next;

    // An insert takes the new word at its slot and shifts later cells up by one.
    // A delete pulls every cell from the removed element onward down by one.
    always_comb
    begin
        value_next = value_reg;
        if (cmd.ins)
        begin
            if (MY_SLOT == position)
            begin
                value_next = new_value;
            end
            else if (MY_SLOT > position)
            begin
                value_next = lower_value;
            end
        end
        else if (cmd.del)
        begin
            if (MY_NUM >= position)
            begin
                value_next = upper_value;
            end
        end
    end

    // Element storage holds no reset value; slots past the count are never shown.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value   = value_reg;
    // Read tap: this cell drives the read bus only when it holds the requested element.
    assign rd_word = (MY_NUM == position) ? value_reg : '0;

endmodule
